// ===== rtl/core/spq_pkg.sv =====
// shared types and constants for the strict priority run queue
package spq_pkg;

    localparam int ID_W     = 8;
    localparam int LVL_W    = 3;
    localparam int DROP_W   = 9;
    localparam int DROP_MAX = 511;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_FLUSH   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NONE    = 2'd2,
        ST_FLUSHED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_ENQ    = 3'd1,
        OP_REJECT = 3'd2,
        OP_DEQ    = 3'd3,
        OP_FLUSH  = 3'd4
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [ID_W-1:0]   id;
        logic [LVL_W-1:0]  lvl;
    } op_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   next_thread;
        logic [LVL_W-1:0]  served_level;
        logic [DROP_W-1:0] dropped_count;
    } res_t;

endpackage

// ===== rtl/core/spq_fifo.sv =====
// small register fifo used between the front and back and on the result side
module spq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        if (p == IW'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full    = (fill_reg == FW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign fill    = fill_reg;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/spq_front.sv =====
// front end: takes items and classifies each command before it is queued
module spq_front import spq_pkg::*; #(
    parameter int LEVELS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [1:0]       command,
    input  logic [ID_W-1:0]  thread_id,
    input  logic [LVL_W-1:0] priority_req,
    output logic             full,
    output logic             op_valid,
    output op_t              op,
    input  logic             op_full
);

    logic valid_reg, valid_next;
    op_t  op_reg, op_next;
    logic accept;
    logic hand_off;

    assign hand_off = valid_reg && !op_full;
    assign full     = valid_reg && op_full;
    assign accept   = push && !full;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_comb
    begin
        op_next.id  = thread_id;
        op_next.lvl = priority_req;
        unique case (cmd_t'(command))
            CMD_ENQUEUE: op_next.kind = (32'(priority_req) < LEVELS) ? OP_ENQ : OP_REJECT;
            CMD_DEQUEUE: op_next.kind = OP_DEQ;
            CMD_FLUSH:   op_next.kind = OP_FLUSH;
            default:     op_next.kind = OP_NOP;
        endcase

        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (hand_off)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

endmodule

// ===== rtl/core/spq_back.sv =====
// back end: per-level pointers and counts, the id store, and the result stage
module spq_back import spq_pkg::*; #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    input  op_t  op,
    input  logic room,
    output logic op_pop,
    output logic res_valid,
    output res_t res
);

    localparam int LW    = $clog2(LEVELS);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = LEVELS * QUEUE_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int TW    = $clog2(SLOTS + 1);

    logic [PW-1:0]   head_reg  [LEVELS];
    logic [PW-1:0]   head_next [LEVELS];
    logic [PW-1:0]   tail_reg  [LEVELS];
    logic [PW-1:0]   tail_next [LEVELS];
    logic [CW-1:0]   count_reg [LEVELS];
    logic [CW-1:0]   count_next[LEVELS];
    logic [TW-1:0]   total_reg, total_next;
    logic            s2_valid_reg;
    res_t            s2_res_reg, s2_res_next;
    logic            s2_rd_reg, s2_rd_next;
    logic [ID_W-1:0] rd_data_reg;
    logic [ID_W-1:0] store_mem [SLOTS];

    logic            exec;
    logic [LW-1:0]   lvl_idx;
    logic            enq_full;
    logic            found;
    logic [LW-1:0]   sel;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            do_write;
    logic            do_read;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign exec     = op_valid && room;
    assign op_pop   = exec;
    assign lvl_idx  = LW'(op.lvl);
    assign enq_full = (count_reg[lvl_idx] == CW'(QUEUE_DEPTH));

    // lowest numbered non-empty level wins
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                found = 1'b1;
                sel   = LW'(i);
            end
        end
    end

    assign wr_addr  = AW'(AW'(lvl_idx) * AW'(QUEUE_DEPTH)) + AW'(tail_reg[lvl_idx]);
    assign rd_addr  = AW'(AW'(sel) * AW'(QUEUE_DEPTH)) + AW'(head_reg[sel]);
    assign do_write = exec && (op.kind == OP_ENQ) && !enq_full;
    assign do_read  = exec && (op.kind == OP_DEQ) && found;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        total_next = total_reg;
        s2_rd_next = 1'b0;
        s2_res_next.status        = ST_OK;
        s2_res_next.next_thread   = '0;
        s2_res_next.served_level  = '0;
        s2_res_next.dropped_count = '0;

        if (exec)
        begin
            case (op.kind)
                OP_ENQ:
                begin
                    if (enq_full)
                    begin
                        s2_res_next.status = ST_FULL;
                    end
                    else
                    begin
                        tail_next[lvl_idx]  = bump(tail_reg[lvl_idx]);
                        count_next[lvl_idx] = count_reg[lvl_idx] + 1'b1;
                        total_next          = total_reg + 1'b1;
                    end
                end
                OP_REJECT:
                begin
                    s2_res_next.status = ST_FULL;
                end
                OP_DEQ:
                begin
                    if (found)
                    begin
                        head_next[sel]           = bump(head_reg[sel]);
                        count_next[sel]          = count_reg[sel] - 1'b1;
                        total_next               = total_reg - 1'b1;
                        s2_res_next.served_level = LVL_W'(sel);
                        s2_rd_next               = 1'b1;
                    end
                    else
                    begin
                        s2_res_next.status = ST_NONE;
                    end
                end
                OP_FLUSH:
                begin
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        head_next[i]  = '0;
                        tail_next[i]  = '0;
                        count_next[i] = '0;
                    end
                    total_next         = '0;
                    s2_res_next.status = ST_FLUSHED;
                    s2_res_next.dropped_count = (32'(total_reg) > DROP_MAX)
                        ? DROP_W'(DROP_MAX) : DROP_W'(total_reg);
                end
                default:
                begin
                    s2_res_next.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg    <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            s2_valid_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            s2_res_reg <= s2_res_next;
            s2_rd_reg  <= s2_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_mem[wr_addr] <= op.id;
        end
        if (do_read)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb
    begin
        res             = s2_res_reg;
        res.next_thread = s2_rd_reg ? rd_data_reg : '0;
    end

    assign res_valid = s2_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg == $past(exec))
        else $error("result stage out of step with execute");

    assert property (@(posedge clk) disable iff (!rst_n)
        exec && (op.kind == OP_FLUSH) |=> (total_reg == '0) && (count_reg[0] == '0))
        else $error("flush left ids behind");

    assert property (@(posedge clk) disable iff (!rst_n)
        exec && (op.kind == OP_DEQ) && found |=> total_reg == $past(total_reg) - 1'b1)
        else $error("dequeue did not reduce the total");

endmodule

// ===== rtl/core/strict_priority_run_queue.sv =====
// Strict priority run queue: one fifo of thread ids per priority level, level 0
// served first. Commands are enqueue, dequeue (head of the lowest numbered
// non-empty level, or "nothing ready") and flush (drop everything and report
// how many ids went). Every item yields exactly one result item. One item per
// clock is sustained as long as results are popped; each command is carried
// out in the execute step, which updates the pointers and counts of the level it
// touches (all levels on a flush) and uses the id store at most once. A result
// passes from the front register through the command queue, the execute step and
// the store read stage into the result queue. There is no clearing pass after reset.
module strict_priority_run_queue import spq_pkg::*; #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        command,
    input  logic [ID_W-1:0]   thread_id,
    input  logic [LVL_W-1:0]  priority_req,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   next_thread,
    output logic [LVL_W-1:0]  served_level,
    output logic [DROP_W-1:0] dropped_count
);

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int MFW       = $clog2(MID_DEPTH + 1);
    localparam int OFW       = $clog2(OUT_DEPTH + 1);

    logic           front_valid;
    op_t            front_op;
    logic           mid_full;
    logic           mid_empty;
    op_t            mid_op;
    logic [MFW-1:0] mid_fill;
    logic           mid_pop;
    logic           room;
    logic           res_valid;
    res_t           res;
    res_t           out_res;
    logic           out_full;
    logic [OFW-1:0] out_fill;

    spq_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .command      (command),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .full         (full),
        .op_valid     (front_valid),
        .op           (front_op),
        .op_full      (mid_full)
    );

    spq_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_op),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_op),
        .empty (mid_empty),
        .fill  (mid_fill)
    );

    // reserve a result slot for the item in the read stage
    assign room = (out_fill + OFW'(res_valid)) < OFW'(OUT_DEPTH);

    spq_back #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (!mid_empty),
        .op        (mid_op),
        .room      (room),
        .op_pop    (mid_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    spq_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty),
        .fill  (out_fill)
    );

    assign status        = out_res.status;
    assign next_thread   = out_res.next_thread;
    assign served_level  = out_res.served_level;
    assign dropped_count = out_res.dropped_count;

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_full)
        else $error("result item arrived at a full result queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> (mid_fill != '0) && room)
        else $error("command taken without a queued item or result slot");

endmodule

// ===== test/tb_strict_priority_run_queue.sv =====
// self-checking testbench for the strict priority run queue
module tb_strict_priority_run_queue;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 32;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    class run_queue_scoreboard;
        logic [ID_W-1:0] id_store [NUM_LEVELS][LEVEL_DEPTH];
        int unsigned     rd_slot [NUM_LEVELS];
        int unsigned     wr_slot [NUM_LEVELS];
        int unsigned     occupancy [NUM_LEVELS];
        res_t            pending_results [$];
        int unsigned     error_count;

        function int unsigned queued_total();
            int unsigned total;
            total = 0;
            for (int l = 0; l < NUM_LEVELS; l++)
                total += occupancy[l];
            return total;
        endfunction

        // apply one accepted item and queue the result it must produce
        function void predict_item(logic [1:0] cmd, logic [ID_W-1:0] id,
                                   logic [LVL_W-1:0] lvl);
            res_t        r;
            bit          found;
            int unsigned total;
            r = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_ENQUEUE:
                begin
                    if (occupancy[lvl] >= LEVEL_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        id_store[lvl][wr_slot[lvl]] = id;
                        wr_slot[lvl] = (wr_slot[lvl] + 1) % LEVEL_DEPTH;
                        occupancy[lvl]++;
                    end
                end
                CMD_DEQUEUE:
                begin
                    found = 1'b0;
                    for (int l = 0; l < NUM_LEVELS; l++)
                    begin
                        if (!found && occupancy[l] != 0)
                        begin
                            r.next_thread  = id_store[l][rd_slot[l]];
                            r.served_level = LVL_W'(l);
                            rd_slot[l] = (rd_slot[l] + 1) % LEVEL_DEPTH;
                            occupancy[l]--;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = ST_NONE;
                end
                CMD_FLUSH:
                begin
                    total = queued_total();
                    for (int l = 0; l < NUM_LEVELS; l++)
                    begin
                        rd_slot[l]   = 0;
                        wr_slot[l]   = 0;
                        occupancy[l] = 0;
                    end
                    r.dropped_count = (total > DROP_MAX) ? DROP_W'(DROP_MAX) : DROP_W'(total);
                    r.status = ST_FLUSHED;
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [ID_W-1:0] nt,
                                   logic [LVL_W-1:0] sl, logic [DROP_W-1:0] dc);
            res_t e;
            if (pending_results.size() == 0)
            begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual status %0d thread %0d level %0d dropped %0d"},
                         $time, st, nt, sl, dc);
                error_count++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                error_count++;
            end
            if (nt !== e.next_thread)
            begin
                $display("%0t: next_thread expected %0d actual %0d",
                         $time, e.next_thread, nt);
                error_count++;
            end
            if (sl !== e.served_level)
            begin
                $display("%0t: served_level expected %0d actual %0d",
                         $time, e.served_level, sl);
                error_count++;
            end
            if (dc !== e.dropped_count)
            begin
                $display("%0t: dropped_count expected %0d actual %0d",
                         $time, e.dropped_count, dc);
                error_count++;
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              push         = 1'b0;
    logic              full;
    logic [1:0]        command      = '0;
    logic [ID_W-1:0]   thread_id    = '0;
    logic [LVL_W-1:0]  priority_req = '0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [1:0]        status;
    logic [ID_W-1:0]   next_thread;
    logic [LVL_W-1:0]  served_level;
    logic [DROP_W-1:0] dropped_count;

    run_queue_scoreboard sb;
    bit                  quiet      = 1'b0;
    int unsigned         items_sent = 0;

    always #4 clk = ~clk;

    strict_priority_run_queue #(
        .LEVELS      (NUM_LEVELS),
        .QUEUE_DEPTH (LEVEL_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .thread_id     (thread_id),
        .priority_req  (priority_req),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .next_thread   (next_thread),
        .served_level  (served_level),
        .dropped_count (dropped_count)
    );

    // called at a falling edge, returns at a falling edge after the item is taken
    task automatic send_item(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [LVL_W-1:0] lvl);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        command      <= cmd;
        thread_id    <= id;
        priority_req <= lvl;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.predict_item(cmd, id, lvl);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic run_mixed(input int unsigned n);
        int unsigned pick;
        logic [LVL_W-1:0] lvl;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            // lean on the top levels so the priority order actually matters
            lvl = $urandom_range(0, 1) ? LVL_W'($urandom_range(0, 2))
                                       : LVL_W'($urandom_range(0, 7));
            if (pick < 52)
                send_item(CMD_ENQUEUE, ID_W'($urandom_range(0, 255)), lvl);
            else if (pick < 92)
                send_item(CMD_DEQUEUE, ID_W'($urandom_range(0, 255)),
                          LVL_W'($urandom_range(0, 7)));
            else if (pick < 96)
                send_item(CMD_FLUSH, ID_W'($urandom_range(0, 255)),
                          LVL_W'($urandom_range(0, 7)));
            else
                send_item(CMD_RESERVED, ID_W'($urandom_range(0, 255)),
                          LVL_W'($urandom_range(0, 7)));
        end
    endtask

    // push one level past its depth, then pull a few back out
    task automatic overflow_level(input logic [LVL_W-1:0] lvl);
        int unsigned n;
        n = LEVEL_DEPTH - sb.occupancy[lvl] + $urandom_range(1, 4);
        repeat (n)
            send_item(CMD_ENQUEUE, ID_W'($urandom_range(0, 255)), lvl);
        n = $urandom_range(0, 8);
        repeat (n)
            send_item(CMD_DEQUEUE, ID_W'($urandom_range(0, 255)), LVL_W'($urandom_range(0, 7)));
    endtask

    task automatic drain_queues();
        int unsigned n;
        n = sb.queued_total();
        n = (n > 40) ? 20 : n + $urandom_range(1, 3);
        repeat (n)
            send_item(CMD_DEQUEUE, ID_W'($urandom_range(0, 255)), LVL_W'($urandom_range(0, 7)));
    endtask

    task automatic fill_all_and_flush();
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            while (sb.occupancy[l] < LEVEL_DEPTH)
                send_item(CMD_ENQUEUE, ID_W'($urandom_range(0, 255)), LVL_W'(l));
            send_item(CMD_ENQUEUE, ID_W'($urandom_range(0, 255)), LVL_W'(l));
        end
        send_item(CMD_FLUSH, '0, '0);
    endtask

    // result side: random stall bursts, none once the run goes quiet
    initial
    begin
        int unsigned stall;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !quiet)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if (quiet || $urandom_range(0, 11) != 0)
            begin
                pop <= 1'b1;
            end
            else
            begin
                pop <= 1'b0;
                stall = $urandom_range(1, 11) - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(status, next_thread, served_level, dropped_count);
    end

    initial
    begin
        int unsigned target;
        int unsigned pick;
        sb = new;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty cases, reserved command, id and level extremes, priority order
        send_item(CMD_DEQUEUE, 8'hFF, 3'd7);
        send_item(CMD_FLUSH, 8'hFF, 3'd7);
        send_item(CMD_RESERVED, 8'hFF, 3'd7);
        send_item(CMD_ENQUEUE, 8'h00, 3'd0);
        send_item(CMD_ENQUEUE, 8'hFF, 3'd7);
        send_item(CMD_ENQUEUE, 8'hA5, 3'd3);
        send_item(CMD_ENQUEUE, 8'h5A, 3'd3);
        send_item(CMD_ENQUEUE, 8'h01, 3'd0);
        send_item(CMD_RESERVED, 8'h00, 3'd0);
        repeat (6)
            send_item(CMD_DEQUEUE, 8'h00, 3'd0);
        send_item(CMD_ENQUEUE, 8'h80, 3'd6);
        send_item(CMD_ENQUEUE, 8'h7F, 3'd2);
        send_item(CMD_FLUSH, 8'h00, 3'd0);
        send_item(CMD_DEQUEUE, 8'h00, 3'd0);

        // random: one full-store flush, then episodes of mixed traffic
        target = items_sent + 620;
        fill_all_and_flush();
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                run_mixed($urandom_range(20, 40));
            else if (pick < 7)
                overflow_level(LVL_W'($urandom_range(0, 7)));
            else
                drain_queues();
        end
        quiet = 1'b1;
        run_mixed(80);
        drain_queues();
        push <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.error_count == 0)
            $display("strict_priority_run_queue verification clean");
        else
            $display("strict_priority_run_queue verification failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("strict_priority_run_queue verification failed");
        $finish;
    end

endmodule

// ===== strict_priority_run_queue.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_fifo.sv
rtl/core/spq_front.sv
rtl/core/spq_back.sv
rtl/core/strict_priority_run_queue.sv
test/tb_strict_priority_run_queue.sv
